FILE: src/dtd_pkg.sv
// Shared types and constants for the debounced typed demultiplexer.
// Used by debounced_typed_demultiplexer; depends on nothing else.
package dtd_pkg;

    // channel count limits and derived widths
    localparam int unsigned MAX_CHANNELS = 1024;
    localparam int unsigned SELECT_BITS  = 10;
    localparam int unsigned CH_W         = $clog2(MAX_CHANNELS);
    localparam int unsigned CNT_W        = $clog2(MAX_CHANNELS) + 1;

    // field widths
    localparam int unsigned SEL_W    = 32;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned PERIOD_W = 30;
    localparam int unsigned TIMER_W  = 32;

    // configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // largest positive signed 32-bit value
    localparam logic [VAL_W-1:0] S32_TOP = 32'h7FFF_FFFF;

    // ns to us: floor(p / 1000) == (p * DIV_MULT) >> DIV_SHIFT for p < 2^32
    localparam int unsigned      DIV_SHIFT = 38;
    localparam int unsigned      DIV_MW    = 29;
    localparam logic [DIV_MW-1:0] DIV_MULT = 29'd274877907;
    localparam int unsigned      QUOT_W    = PERIOD_W + DIV_MW - DIV_SHIFT;

    // value type codes
    typedef enum logic [1:0] {
        TYPE_BIT = 2'd0,
        TYPE_S32 = 2'd1,
        TYPE_U32 = 2'd2
    } t_val_type;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CHANNELS = 3'd0,
        REG_IN_TYPE  = 3'd1,
        REG_OUT_TYPE = 3'd2,
        REG_DEBOUNCE = 3'd3,
        REG_SUPPRESS = 3'd4
    } t_reg_index;

    // converted value plus a flag for a meaningful type pair
    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] value;
    } t_conv;

    // saturating type conversion between bit, signed and unsigned words
    function automatic t_conv convert(input logic [1:0] in_type,
                                      input logic [1:0] dst_type,
                                      input logic [VAL_W-1:0] raw);
        t_conv res;
        res.ok    = 1'b1;
        res.value = '0;
        if (dst_type != TYPE_BIT && dst_type != TYPE_S32 && dst_type != TYPE_U32) begin
            res.ok = 1'b0;
        end else begin
            case (in_type)
                TYPE_BIT: begin
                    res.value = {{(VAL_W-1){1'b0}}, raw[0]};
                end
                TYPE_S32: begin
                    case (dst_type)
                        TYPE_BIT: res.value = {{(VAL_W-1){1'b0}}, |raw};
                        TYPE_S32: res.value = raw;
                        default:  res.value = raw[VAL_W-1] ? '0 : raw;
                    endcase
                end
                TYPE_U32: begin
                    case (dst_type)
                        TYPE_BIT: res.value = {{(VAL_W-1){1'b0}}, |raw};
                        TYPE_S32: res.value = (raw > S32_TOP) ? S32_TOP : raw;
                        default:  res.value = raw;
                    endcase
                end
                default: begin
                    res.ok = 1'b0;
                end
            endcase
        end
        return res;
    endfunction

endpackage

FILE: src/debounced_typed_demultiplexer.sv
// Top level of the debounced typed demultiplexer: three-register pipeline.
// Depends on dtd_pkg for widths, type codes, register indexes and convert().
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per tick: select
//   bits, select number, the raw value and the nanoseconds since the last
//   tick. Output channel (o_out_valid / i_out_stall) returns one word per
//   input word: whether a channel was written, its index and new value, the
//   accepted selection and the debounce timer.
//   Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_data while
//   the block is idle; registers are channel count, input type, output type,
//   debounce limit in microseconds and the zero-suppress flag.
//   A word passes the input register, the convert/divide register and the
//   result register before its result is valid.
//   Throughput: one word per cycle while the receiver does not stall. The
//   ns-to-us divide is a reciprocal multiply in the middle stage; the
//   debounce state updates in the last stage, once per word.
//   Reset (synchronous, active low) empties the pipeline, loads the register
//   defaults (two channels, bit types, no debounce, no suppression) and
//   clears the accepted selection and the timer.
//   When the receiver stalls, the result register holds and earlier stages
//   keep filling until the pipeline is full; then o_in_stall rises.
module debounced_typed_demultiplexer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [dtd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [dtd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [dtd_pkg::SELECT_BITS-1:0]  i_select_bits,
    input  logic [dtd_pkg::SEL_W-1:0]        i_select_number,
    input  logic [dtd_pkg::VAL_W-1:0]        i_in_value,
    input  logic [dtd_pkg::PERIOD_W-1:0]     i_period_ns,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_write_done,
    output logic [dtd_pkg::CH_W-1:0]         o_channel,
    output logic [dtd_pkg::VAL_W-1:0]        o_channel_value,
    output logic [dtd_pkg::SEL_W-1:0]        o_selected,
    output logic [dtd_pkg::TIMER_W-1:0]      o_elapsed_us
);
    import dtd_pkg::*;

    // configuration registers
    logic [CNT_W-1:0]   r_channels;
    logic [1:0]         r_in_type;
    logic [1:0]         r_dst_type;
    logic [TIMER_W-1:0] r_debounce;
    logic               r_suppress;

    // stage 0: registered input word
    logic                   r_s0_valid;
    logic [SELECT_BITS-1:0] r_s0_bits;
    logic [SEL_W-1:0]       r_s0_number;
    logic [VAL_W-1:0]       r_s0_value;
    logic [PERIOD_W-1:0]    r_s0_period;

    // stage 1: selection, clamped index, converted value, period in us
    logic               r_s1_valid;
    logic [SEL_W-1:0]   r_s1_sel;
    logic [CH_W-1:0]    r_s1_idx;
    t_conv              r_s1_conv;
    logic [QUOT_W-1:0]  r_s1_us;

    // debounce state
    logic [SEL_W-1:0]   r_accepted;
    logic [TIMER_W-1:0] r_timer;

    // result register
    logic               r_out_valid;
    logic               r_out_done;
    logic [CH_W-1:0]    r_out_channel;
    logic [VAL_W-1:0]   r_out_value;

    // stage advance enables
    logic en_out;
    logic en_s1;
    logic en_s0;

    assign en_out = !r_out_valid || !i_out_stall;
    assign en_s1  = !r_s1_valid || en_out;
    assign en_s0  = !r_s0_valid || en_s1;
    assign o_in_stall = !en_s0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels <= CNT_W'(2);
            r_in_type  <= TYPE_BIT;
            r_dst_type <= TYPE_BIT;
            r_debounce <= '0;
            r_suppress <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CHANNELS: r_channels <= i_cfg_data[CNT_W-1:0];
                REG_IN_TYPE:  r_in_type  <= i_cfg_data[1:0];
                REG_OUT_TYPE: r_dst_type <= i_cfg_data[1:0];
                REG_DEBOUNCE: r_debounce <= i_cfg_data[TIMER_W-1:0];
                REG_SUPPRESS: r_suppress <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage 0 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en_s0) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s0 && i_in_valid) begin
            r_s0_bits   <= i_select_bits;
            r_s0_number <= i_select_number;
            r_s0_value  <= i_in_value;
            r_s0_period <= i_period_ns;
        end
    end

    // effective channel count, clamped to the legal range
    logic [CNT_W-1:0]       eff_count;
    logic [CNT_W-1:0]       last_ch;
    logic                   is_pow2;
    logic [SELECT_BITS-1:0] bits_used;
    logic [SEL_W-1:0]       n_sel;
    logic [CH_W-1:0]        n_idx;
    logic [PERIOD_W+DIV_MW-1:0] prod;

    always_comb begin
        if (r_channels < CNT_W'(2)) begin
            eff_count = CNT_W'(2);
        end else if (r_channels > CNT_W'(MAX_CHANNELS)) begin
            eff_count = CNT_W'(MAX_CHANNELS);
        end else begin
            eff_count = r_channels;
        end
        last_ch = eff_count - CNT_W'(1);
        is_pow2 = (eff_count & last_ch) == '0;
    end

    // select bits count only for a power-of-two count; mask is count minus one
    always_comb begin
        bits_used = is_pow2 ? (r_s0_bits & last_ch[SELECT_BITS-1:0]) : '0;
        n_sel     = SEL_W'(bits_used) + r_s0_number;
        if (n_sel >= SEL_W'(eff_count)) begin
            n_idx = last_ch[CH_W-1:0];
        end else begin
            n_idx = n_sel[CH_W-1:0];
        end
    end

    // ns to us by reciprocal multiply
    assign prod = PERIOD_W'(r_s0_period) * DIV_MULT;

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en_s1) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1 && r_s0_valid) begin
            r_s1_sel  <= n_sel;
            r_s1_idx  <= n_idx;
            r_s1_conv <= convert(r_in_type, r_dst_type, r_s0_value);
            r_s1_us   <= prod[PERIOD_W+DIV_MW-1:DIV_SHIFT];
        end
    end

    // debounce decision and timer update
    logic               take;
    logic               n_done;
    logic [SEL_W-1:0]   n_accepted;
    logic [TIMER_W-1:0] n_timer;
    logic [TIMER_W:0]   timer_sum;

    assign take = en_out && r_s1_valid;

    always_comb begin
        timer_sum  = {1'b0, r_timer} + (TIMER_W+1)'(r_s1_us);
        n_accepted = r_accepted;
        n_timer    = r_timer;
        n_done     = 1'b0;
        if (r_suppress && r_s1_sel == '0) begin
            // suppressed zero selection: nothing changes
        end else if (r_s1_sel != r_accepted && r_timer < r_debounce) begin
            n_timer = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
        end else begin
            n_accepted = r_s1_sel;
            n_timer    = '0;
            n_done     = r_s1_conv.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted <= '0;
            r_timer    <= '0;
        end else if (take) begin
            r_accepted <= n_accepted;
            r_timer    <= n_timer;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_done    <= n_done;
            r_out_channel <= n_done ? r_s1_idx : '0;
            r_out_value   <= n_done ? r_s1_conv.value : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_done    = r_out_done;
    assign o_channel       = r_out_channel;
    assign o_channel_value = r_out_value;
    assign o_selected      = r_accepted;
    assign o_elapsed_us    = r_timer;

endmodule

FILE: bench/tb_debounced_typed_demultiplexer.sv
// Self-checking bench for the debounced typed demultiplexer: directed and random ticks
// against an in-bench prediction of selection, hold timer and type conversion.
// Depends on dtd_pkg and debounced_typed_demultiplexer from src.
`timescale 1ns / 1ps

module tb_debounced_typed_demultiplexer;
    import dtd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned NS_PER_US    = 1000;
    localparam int unsigned RANDOM_TICKS = 1450;
    localparam int unsigned HOLD_TICKS   = 250;

    // one result word as the block reports it
    typedef struct packed {
        logic               write_done;
        logic [CH_W-1:0]    channel;
        logic [VAL_W-1:0]   channel_value;
        logic [SEL_W-1:0]   selected;
        logic [TIMER_W-1:0] elapsed_us;
    } t_demux_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [SELECT_BITS-1:0]  i_select_bits = '0;
    logic [SEL_W-1:0]        i_select_number = '0;
    logic [VAL_W-1:0]        i_in_value = '0;
    logic [PERIOD_W-1:0]     i_period_ns = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_write_done;
    logic [CH_W-1:0]         o_channel;
    logic [VAL_W-1:0]        o_channel_value;
    logic [SEL_W-1:0]        o_selected;
    logic [TIMER_W-1:0]      o_elapsed_us;

    // mirrored registers, reset values
    logic [10:0]  cfg_count    = 11'd2;
    logic [1:0]   cfg_in_type  = TYPE_BIT;
    logic [1:0]   cfg_dst_type = TYPE_BIT;
    logic [31:0]  cfg_debounce = '0;
    logic         cfg_suppress = 1'b0;

    // mirrored debounce state
    logic [SEL_W-1:0]   held_selection = '0;
    logic [TIMER_W-1:0] hold_us = '0;

    t_demux_word expected_words[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          src_gaps = 1'b1;
    bit          sink_stalls = 1'b1;

    debounced_typed_demultiplexer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_select_bits   (i_select_bits),
        .i_select_number (i_select_number),
        .i_in_value      (i_in_value),
        .i_period_ns     (i_period_ns),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_done    (o_write_done),
        .o_channel       (o_channel),
        .o_channel_value (o_channel_value),
        .o_selected      (o_selected),
        .o_elapsed_us    (o_elapsed_us)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still outstanding", $time, expected_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // channel count as the block uses it
    function automatic logic [31:0] eff_count();
        logic [31:0] n;
        n = {21'b0, cfg_count};
        if (n < 2) n = 2;
        if (n > MAX_CHANNELS) n = MAX_CHANNELS;
        return n;
    endfunction

    // select bits in use: low log2(n) bits for a power of two, none otherwise
    function automatic logic [31:0] sel_mask(input logic [31:0] n);
        int unsigned w;
        w = 0;
        if ((n & (n - 1)) != 0) return '0;
        while ((32'd1 << w) < n) w++;
        return (32'd1 << w) - 1;
    endfunction

    // expected word for one tick; advances the mirrored debounce state
    function automatic t_demux_word predict_demux_word(input logic [SELECT_BITS-1:0] bits,
                                                       input logic [SEL_W-1:0] number,
                                                       input logic [VAL_W-1:0] raw,
                                                       input logic [PERIOD_W-1:0] period);
        t_demux_word w;
        logic [31:0] n;
        logic [31:0] sel;
        logic [31:0] add;
        logic [31:0] idx;
        logic [31:0] conv;
        logic        ok;
        w   = '0;
        n   = eff_count();
        sel = ({22'b0, bits} & sel_mask(n)) + number;
        if (cfg_suppress && sel == 0) begin
            // zero selection ignored entirely
        end else if (sel != held_selection && hold_us < cfg_debounce) begin
            add     = period / NS_PER_US;
            hold_us = (hold_us > 32'hFFFF_FFFF - add) ? 32'hFFFF_FFFF : hold_us + add;
        end else begin
            held_selection = sel;
            hold_us        = '0;
            ok             = 1'b1;
            conv           = '0;
            if (cfg_in_type > TYPE_U32 || cfg_dst_type > TYPE_U32) begin
                ok = 1'b0;
            end else if (cfg_in_type == TYPE_BIT) begin
                conv = {31'b0, raw[0]};
            end else if (cfg_dst_type == TYPE_BIT) begin
                conv = {31'b0, raw != 0};
            end else if (cfg_in_type == TYPE_S32) begin
                conv = (cfg_dst_type == TYPE_U32 && raw[31]) ? 32'h0 : raw;
            end else begin
                conv = (cfg_dst_type == TYPE_S32 && raw > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : raw;
            end
            if (ok) begin
                idx             = (sel >= n) ? n - 1 : sel;
                w.write_done    = 1'b1;
                w.channel       = idx[CH_W-1:0];
                w.channel_value = conv;
            end
        end
        w.selected   = held_selection;
        w.elapsed_us = hold_us;
        return w;
    endfunction

    // random source gap: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned pct;
        if (!src_gaps) return 0;
        pct = $urandom_range(0, 99);
        if (pct < 70) return 0;
        if (pct < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sink stall pattern
    always @(posedge i_clk) begin : sink_stall_gen
        int unsigned pct;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!sink_stalls) begin
            i_out_stall <= 1'b0;
        end else begin
            pct = $urandom_range(0, 99);
            if (pct < 65) begin
                i_out_stall <= 1'b0;
            end else if (pct < 93) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(6, 30);
            end
        end
    end

    // compare every accepted result word with the oldest expected one
    always @(posedge i_clk) begin : check_words
        t_demux_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                fail_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_write_done !== exp_w.write_done) begin
                    $display("%0t: write_done expected %h got %h", $time,
                             exp_w.write_done, o_write_done);
                    fail_count++;
                end
                if (o_channel !== exp_w.channel) begin
                    $display("%0t: channel expected %h got %h", $time, exp_w.channel, o_channel);
                    fail_count++;
                end
                if (o_channel_value !== exp_w.channel_value) begin
                    $display("%0t: channel_value expected %h got %h", $time,
                             exp_w.channel_value, o_channel_value);
                    fail_count++;
                end
                if (o_selected !== exp_w.selected) begin
                    $display("%0t: selected expected %h got %h", $time, exp_w.selected, o_selected);
                    fail_count++;
                end
                if (o_elapsed_us !== exp_w.elapsed_us) begin
                    $display("%0t: elapsed_us expected %h got %h", $time,
                             exp_w.elapsed_us, o_elapsed_us);
                    fail_count++;
                end
            end
        end
    end

    // send one input word and record its expected result
    task automatic send_tick(input logic [SELECT_BITS-1:0] bits, input logic [SEL_W-1:0] number,
                             input logic [VAL_W-1:0] value, input logic [PERIOD_W-1:0] period);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_select_bits   <= bits;
        i_select_number <= number;
        i_in_value      <= value;
        i_period_ns     <= period;
        do @(posedge i_clk); while (o_in_stall);
        expected_words.push_back(predict_demux_word(bits, number, value, period));
    endtask

    // hit a target selection with random select bits and a matching number
    task automatic send_selection(input logic [31:0] target, input logic [VAL_W-1:0] value,
                                  input logic [PERIOD_W-1:0] period);
        logic [SELECT_BITS-1:0] bits;
        bits = SELECT_BITS'($urandom);
        send_tick(bits, target - ({22'b0, bits} & sel_mask(eff_count())), value, period);
    endtask

    // drop valid and let every outstanding word drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // single register write, junk above the register width now and then
    task automatic write_reg(input t_reg_index idx, input logic [31:0] value);
        logic [31:0] data;
        int unsigned wid;
        case (idx)
            REG_CHANNELS: wid = 11;
            REG_IN_TYPE:  wid = 2;
            REG_OUT_TYPE: wid = 2;
            REG_DEBOUNCE: wid = 32;
            default:      wid = 1;
        endcase
        data = value;
        if (wid < 32 && $urandom_range(0, 1))
            data = (value & ((32'd1 << wid) - 1)) | ($urandom << wid);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_CHANNELS: cfg_count    = data[10:0];
            REG_IN_TYPE:  cfg_in_type  = data[1:0];
            REG_OUT_TYPE: cfg_dst_type = data[1:0];
            REG_DEBOUNCE: cfg_debounce = data;
            default:      cfg_suppress = data[0];
        endcase
    endtask

    task automatic set_config(input logic [10:0] count, input logic [1:0] in_type,
                              input logic [1:0] dst_type, input logic [31:0] debounce,
                              input logic suppress);
        wait_idle();
        write_reg(REG_CHANNELS, {21'b0, count});
        write_reg(REG_IN_TYPE, {30'b0, in_type});
        write_reg(REG_OUT_TYPE, {30'b0, dst_type});
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_SUPPRESS, {31'b0, suppress});
    endtask

    // reset configuration: two channels, bit types, wrapping selection
    task automatic test_reset_defaults();
        send_tick(10'h3FF, 32'h0000_0000, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        send_tick(10'h001, 32'hFFFF_FFFF, 32'h0000_0000, 30'h0);
        send_tick(10'h000, 32'h8000_0000, 32'h0000_0001, 30'h0);
    endtask

    // every input/output type pair, including the undefined code
    task automatic test_type_pairs();
        logic [31:0] probe[8];
        probe = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0002,
                  32'h8000_0001, 32'h0000_0000, 32'h0000_0001, 32'h9000_0000};
        for (int it = 0; it < 4; it++) begin
            for (int ot = 0; ot < 4; ot++) begin
                set_config(11'd8, it[1:0], ot[1:0], 32'h0, 1'b0);
                send_selection((it * 4 + ot) % 8, probe[(it * 4 + ot + it) % 8], 30'h0);
            end
        end
    endtask

    // hold timer builds up, truncated microseconds, zero suppression
    task automatic test_debounce_hold();
        set_config(11'd16, TYPE_S32, TYPE_S32, 32'd5, 1'b1);
        send_selection(32'd0, 32'h1234_5678, 30'd5000);
        send_selection(32'd7, 32'hFFFF_FFFF, 30'd3000);
        send_selection(32'd7, 32'hFFFF_FFFF, 30'd999);
        send_selection(32'd7, 32'hFFFF_FFFF, 30'd2999);
        send_selection(32'd7, 32'h8000_0000, 30'd0);
        send_selection(32'd7, 32'h7FFF_FFFF, 30'd0);
        send_selection(32'd0, 32'h0000_0001, 30'd0);
    endtask

    // counts out of range and not a power of two, large selections
    task automatic test_channel_count();
        logic [10:0] counts[6];
        counts = '{11'd0, 11'd1, 11'd3, 11'd1023, 11'd1024, 11'd2047};
        foreach (counts[k]) begin
            set_config(counts[k], TYPE_U32, TYPE_BIT, 32'h0, 1'b0);
            send_tick(10'h3FF, 32'h8000_0000, 32'h0000_0100, 30'h0);
        end
    endtask

    // hold timer keeps growing under the largest debounce limit, back to back
    task automatic test_timer_accumulate();
        logic [31:0] target;
        set_config(11'd4, TYPE_U32, TYPE_U32, 32'hFFFF_FFFF, 1'b0);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        target      = held_selection + 1;
        repeat (HOLD_TICKS) send_selection(target, $urandom, 30'h3FFF_FFFF);
        send_selection(target, 32'hFFFF_FFFF, 30'h0);
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    function automatic logic [31:0] pick_selection(input logic [31:0] n);
        int unsigned pct;
        pct = $urandom_range(0, 99);
        if (pct < 50) return $urandom_range(0, n - 1);
        if (pct < 65) return n - 1 + $urandom_range(0, 3);
        if (pct < 75) return 0;
        if (pct < 85) return $urandom;
        return held_selection;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] edges[6];
        edges = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0001};
        if ($urandom_range(0, 99) < 30) return edges[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        int unsigned pct;
        pct = $urandom_range(0, 99);
        if (pct < 60) return PERIOD_W'($urandom_range(0, 4000));
        if (pct < 80) return PERIOD_W'($urandom_range(0, 999));
        if (pct < 95) return PERIOD_W'($urandom_range(0, 1_000_000_000));
        return PERIOD_W'($urandom);
    endfunction

    // random configurations, runs of steady selections plus noise words
    task automatic test_random_traffic();
        logic [10:0] count_pool[12];
        logic [10:0] count;
        logic [1:0]  in_t;
        logic [1:0]  out_t;
        logic [31:0] deb;
        logic [31:0] target;
        int unsigned sent;
        int unsigned run_len;
        int unsigned pct;
        count_pool = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd7, 11'd8, 11'd64,
                       11'd100, 11'd1023, 11'd1024, 11'd2047};
        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 0) begin
                set_config(11'd1024, TYPE_S32, TYPE_U32, 32'h0, 1'b1);
            end else if (phase == 1) begin
                set_config(11'd2, TYPE_U32, TYPE_S32, 32'd10, 1'b0);
            end else begin
                count = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                                    : count_pool[$urandom_range(0, 11)];
                in_t  = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                out_t = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                pct   = $urandom_range(0, 99);
                if (pct < 30) deb = 0;
                else if (pct < 80) deb = $urandom_range(1, 10);
                else if (pct < 90) deb = $urandom_range(11, 1000);
                else deb = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom;
                set_config(count, in_t, out_t, deb, 1'($urandom_range(0, 1)));
            end
            // every third phase runs back to back on both sides
            src_gaps    = (phase % 3) != 0;
            sink_stalls = (phase % 3) != 0;
            sent = 0;
            while (sent < RANDOM_TICKS / 10) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_tick(SELECT_BITS'($urandom), $urandom, $urandom,
                              PERIOD_W'($urandom));
                    sent++;
                end else begin
                    target  = pick_selection(eff_count());
                    run_len = $urandom_range(1, 8);
                    repeat (run_len) send_selection(target, pick_value(), pick_period());
                    sent += run_len;
                end
            end
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_type_pairs();
        test_debounce_hold();
        test_channel_count();
        test_timer_accumulate();
        test_random_traffic();
        wait_idle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/dtd_pkg.sv
src/debounced_typed_demultiplexer.sv
bench/tb_debounced_typed_demultiplexer.sv
